// ===== rtl/sms_pkg.sv =====
// shared types, constants and opcodes for the stack machine step unit
`default_nettype none
package sms_pkg;

    localparam int unsigned MEM_BYTES_DEF          = 65536;
    localparam int unsigned RETURN_STACK_BYTES_DEF = 1024;

    typedef logic [15:0] word_t;
    typedef logic [7:0]  byte_t;

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // opcodes
    localparam byte_t OP_PSH = 8'd0;
    localparam byte_t OP_POP = 8'd1;
    localparam byte_t OP_DUP = 8'd2;
    localparam byte_t OP_SWP = 8'd3;
    localparam byte_t OP_ROT = 8'd4;
    localparam byte_t OP_OVR = 8'd5;
    localparam byte_t OP_ADD = 8'd6;
    localparam byte_t OP_SUB = 8'd7;
    localparam byte_t OP_MUL = 8'd8;
    localparam byte_t OP_DIV = 8'd9;
    localparam byte_t OP_NOT = 8'd10;
    localparam byte_t OP_AND = 8'd11;
    localparam byte_t OP_OR  = 8'd12;
    localparam byte_t OP_SHL = 8'd13;
    localparam byte_t OP_SHR = 8'd14;
    localparam byte_t OP_EQU = 8'd15;
    localparam byte_t OP_SLT = 8'd16;
    localparam byte_t OP_JMP = 8'd17;
    localparam byte_t OP_JAL = 8'd18;
    localparam byte_t OP_BRA = 8'd19;
    localparam byte_t OP_RET = 8'd20;
    localparam byte_t OP_LDR = 8'd21;
    localparam byte_t OP_STR = 8'd22;
    localparam byte_t OP_LDW = 8'd23;
    localparam byte_t OP_STW = 8'd24;

    // request to the shared alu
    typedef struct packed {
        logic  start;
        byte_t op;
        word_t b;
        word_t a;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/sms_alu.sv =====
// shared alu: registered ops and a bit-serial restoring divider
`default_nettype none
module sms_alu (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sms_pkg::alu_req_t req,
    output sms_pkg::alu_rsp_t    rsp
);
    import sms_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    word_t       quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    word_t       div_reg, div_next;
    logic        done_reg, done_next;
    word_t       res_reg, res_next;
    logic [16:0] trial;
    logic [31:0] prod;

    assign prod  = {16'd0, req.b} * {16'd0, req.a};
    assign trial = {rem_reg[15:0], quo_reg[15]} - {1'b0, div_reg};

    // op select and divider steps
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_next = trial;
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], quo_reg[15]};
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = quo_next;
            end
        end
        else if (req.start)
        begin
            done_next = 1'b1;
            unique case (req.op)
                OP_ADD: res_next = req.b + req.a;
                OP_SUB: res_next = req.b - req.a;
                OP_MUL: res_next = prod[15:0];
                OP_DIV:
                begin
                    if (req.a == 16'd0)
                        res_next = 16'hFFFF;
                    else
                    begin
                        done_next = 1'b0;
                        busy_next = 1'b1;
                        cnt_next  = 5'd16;
                        quo_next  = req.b;
                        rem_next  = 17'd0;
                        div_next  = req.a;
                    end
                end
                OP_AND: res_next = req.b & req.a;
                OP_OR:  res_next = req.b | req.a;
                OP_SHL: res_next = (req.a >= 16'd16) ? 16'd0 : (req.b << req.a[3:0]);
                OP_SHR: res_next = (req.a >= 16'd16) ? 16'd0 : (req.b >> req.a[3:0]);
                OP_EQU: res_next = {15'd0, req.b == req.a};
                OP_NOT: res_next = {15'd0, req.a == 16'd0};
                default: res_next = {15'd0, req.b < req.a};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;
endmodule
`default_nettype wire

// ===== rtl/sms_mem.sv =====
// byte memory with one port and registered read data
`default_nettype none
module sms_mem #(
    parameter int unsigned MEM_BYTES = sms_pkg::MEM_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(MEM_BYTES)-1:0] addr,
    input  wire sms_pkg::byte_t               wdata,
    output sms_pkg::byte_t                    rdata
);
    import sms_pkg::*;

    byte_t mem [MEM_BYTES];
    byte_t rdata_reg;

    // single port, read before write
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/stack_machine_step_unit.sv =====
// stack machine step unit: sequencer, state registers, memory and alu
//
// One input transaction on command/address/write_byte gives exactly one
// result transaction. Command 0 writes a byte, 1 reads a byte, 2 runs the
// instruction at the program counter; command 3 only clears read_byte and illegal_opcode.
// Each item is processed alone: in_ready is low from acceptance until its
// result is taken. Command 3 goes straight to the result; a write passes
// S_MREQ, a read S_MREQ and S_MWAIT. An instruction passes S_MREQ, S_MWAIT
// and S_DEC for each byte read (opcode, immediate, operands), S_MREQ and
// S_DEC for each byte written, further S_DEC sequencing steps, and S_ALU
// and S_AWAIT for the alu, where a division waits for the bit-serial
// divider. Its length is set by the single memory port and that divider.
// The next item can be accepted in the cycle after the result is taken.
// The result holds in its output register while out_ready is low; the
// next item is accepted once it is taken.
// Reset clears pc to 0, return_sp to MEM_BYTES-1 and data_sp to
// MEM_BYTES-1-RETURN_STACK_BYTES. Memory contents are undefined until
// written; reset does not sweep it.
`default_nettype none
module stack_machine_step_unit #(
    parameter int unsigned MEM_BYTES          = sms_pkg::MEM_BYTES_DEF,
    parameter int unsigned RETURN_STACK_BYTES = sms_pkg::RETURN_STACK_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   command,
    input  wire logic [15:0]  address,
    input  wire logic [7:0]   write_byte,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        read_byte,
    output logic [15:0]       program_counter,
    output logic [15:0]       data_stack_pointer,
    output logic [15:0]       return_stack_pointer,
    output logic              illegal_opcode
);
    import sms_pkg::*;

    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam logic [15:0] RSP_RST = 16'(MEM_BYTES - 1);
    localparam logic [15:0] DSP_RST = 16'(MEM_BYTES - 1 - RETURN_STACK_BYTES);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MREQ  = 4'd1;  // issue memory access
    localparam logic [3:0] S_MWAIT = 4'd2;  // capture read data
    localparam logic [3:0] S_DEC   = 4'd3;  // decide next micro step
    localparam logic [3:0] S_ALU   = 4'd4;
    localparam logic [3:0] S_AWAIT = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;

    // micro step kinds: how a memory access is used
    localparam logic [2:0] K_OPC  = 3'd0;  // opcode fetch
    localparam logic [2:0] K_RDW  = 3'd1;  // read word byte into rd
    localparam logic [2:0] K_WRW  = 3'd2;  // write word byte
    localparam logic [2:0] K_CMDR = 3'd3;  // command read
    localparam logic [2:0] K_CMDW = 3'd4;  // command write

    logic [3:0]  state_reg, state_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  step_reg, step_next;
    logic        hi_reg, hi_next;       // which byte of a word
    logic [1:0]  push_left_reg, push_left_next;  // pushes after the current one
    word_t       pc_reg, pc_next;
    word_t       dsp_reg, dsp_next;
    word_t       rsp_reg, rsp_next;
    word_t       maddr_reg, maddr_next;
    byte_t       mwdata_reg, mwdata_next;
    byte_t       op_reg, op_next;
    word_t       rd_reg, rd_next;       // word being read
    word_t       wd_reg, wd_next;       // word being written
    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    word_t       c_reg, c_next;
    byte_t       rb_reg, rb_next;
    logic        bad_reg, bad_next;
    logic        mem_we;
    byte_t       mem_rdata;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    sms_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (maddr_reg[AW-1:0]),
        .wdata (mwdata_reg),
        .rdata (mem_rdata)
    );

    sms_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign mem_we = (state_reg == S_MREQ) &&
                    ((kind_reg == K_WRW) || (kind_reg == K_CMDW));

    assign alu_req.start = (state_reg == S_ALU);
    assign alu_req.op    = op_reg;
    assign alu_req.b     = b_reg;
    assign alu_req.a     = a_reg;

    assign in_ready             = (state_reg == S_IDLE);
    assign out_valid            = (state_reg == S_OUT);
    assign read_byte            = rb_reg;
    assign program_counter      = pc_reg;
    assign data_stack_pointer   = dsp_reg;
    assign return_stack_pointer = rsp_reg;
    assign illegal_opcode       = bad_reg;

    // sequencer
    // each instruction is a list of steps; at S_DEC the step counter picks
    // the next memory access (read byte, write byte) or the alu
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        step_next   = step_reg;
        hi_next     = hi_reg;
        push_left_next = push_left_reg;
        pc_next     = pc_reg;
        dsp_next    = dsp_reg;
        rsp_next    = rsp_reg;
        maddr_next  = maddr_reg;
        mwdata_next = mwdata_reg;
        op_next     = op_reg;
        rd_next     = rd_reg;
        wd_next     = wd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        rb_next     = rb_reg;
        bad_next    = bad_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rb_next  = 8'd0;
                    bad_next = 1'b0;
                    step_next = 4'd0;
                    if (command == CMD_WRITE)
                    begin
                        kind_next   = K_CMDW;
                        maddr_next  = address;
                        mwdata_next = write_byte;
                        state_next  = S_MREQ;
                    end
                    else if (command == CMD_READ)
                    begin
                        kind_next  = K_CMDR;
                        maddr_next = address;
                        state_next = S_MREQ;
                    end
                    else if (command == CMD_EXEC)
                    begin
                        kind_next  = K_OPC;
                        maddr_next = pc_reg;
                        state_next = S_MREQ;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_MREQ:
            begin
                if ((kind_reg == K_WRW) || (kind_reg == K_CMDW))
                    state_next = (kind_reg == K_CMDW) ? S_OUT : S_DEC;
                else
                    state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                unique case (kind_reg)
                    K_OPC:
                    begin
                        op_next   = mem_rdata;
                        step_next = 4'd0;
                        state_next = S_DEC;
                    end
                    K_CMDR:
                    begin
                        rb_next    = mem_rdata;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        if (hi_reg)
                            rd_next = {mem_rdata, rd_reg[7:0]};
                        else
                            rd_next = {rd_reg[15:8], mem_rdata};
                        state_next = S_DEC;
                    end
                endcase
            end
            S_DEC:
            begin
                // word access helpers are inlined: read hi at addr, lo at addr+1
                state_next = S_MREQ;
                step_next  = step_reg + 4'd1;
                unique case (op_reg)
                    OP_PSH:
                    begin
                        unique case (step_reg)
                            4'd0: begin kind_next = K_RDW; hi_next = 1'b1;
                                  maddr_next = pc_reg + 16'd1; end
                            4'd1: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = pc_reg + 16'd2; end
                            4'd2: begin kind_next = K_WRW; maddr_next = dsp_reg;
                                  mwdata_next = rd_reg[7:0]; end
                            4'd3: begin kind_next = K_WRW; maddr_next = dsp_reg - 16'd1;
                                  mwdata_next = rd_reg[15:8]; end
                            default:
                            begin
                                dsp_next = dsp_reg - 16'd2;
                                pc_next  = pc_reg + 16'd3;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    OP_POP:
                    begin
                        dsp_next = dsp_reg + 16'd2;
                        pc_next  = pc_reg + 16'd1;
                        state_next = S_OUT;
                    end
                    OP_DUP, OP_LDR:
                    begin
                        // read top of the source stack, push on data stack
                        unique case (step_reg)
                            4'd0: begin kind_next = K_RDW; hi_next = 1'b1;
                                  maddr_next = ((op_reg == OP_LDR) ? rsp_reg : dsp_reg)
                                               + 16'd1; end
                            4'd1: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = ((op_reg == OP_LDR) ? rsp_reg : dsp_reg)
                                               + 16'd2; end
                            4'd2:
                            begin
                                if (op_reg == OP_LDR)
                                    rsp_next = rsp_reg + 16'd2;
                                kind_next = K_WRW; maddr_next = dsp_reg;
                                mwdata_next = rd_reg[7:0];
                            end
                            4'd3: begin kind_next = K_WRW; maddr_next = dsp_reg - 16'd1;
                                  mwdata_next = rd_reg[15:8]; end
                            default:
                            begin
                                dsp_next = dsp_reg - 16'd2;
                                pc_next  = pc_reg + 16'd1;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    OP_JMP, OP_JAL, OP_STR, OP_NOT, OP_LDW, OP_RET:
                    begin
                        // one pop, then a push, a jump or both
                        unique case (step_reg)
                            4'd0: begin kind_next = K_RDW; hi_next = 1'b1;
                                  maddr_next = ((op_reg == OP_RET) ? rsp_reg : dsp_reg)
                                               + 16'd1; end
                            4'd1: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = ((op_reg == OP_RET) ? rsp_reg : dsp_reg)
                                               + 16'd2; end
                            4'd2:
                            begin
                                a_next = rd_reg;
                                if (op_reg == OP_RET)
                                begin
                                    rsp_next = rsp_reg + 16'd2;
                                    pc_next  = rd_reg;
                                    state_next = S_OUT;
                                end
                                else
                                begin
                                    dsp_next = dsp_reg + 16'd2;
                                    unique case (op_reg)
                                        OP_JMP:
                                        begin
                                            pc_next = rd_reg;
                                            state_next = S_OUT;
                                        end
                                        OP_JAL:
                                        begin
                                            wd_next = pc_reg + 16'd1;
                                            pc_next = rd_reg;
                                            state_next = S_DEC;
                                            step_next  = 4'd4;
                                        end
                                        OP_STR:
                                        begin
                                            wd_next = rd_reg;
                                            pc_next = pc_reg + 16'd1;
                                            state_next = S_DEC;
                                            step_next  = 4'd4;
                                        end
                                        OP_NOT:
                                        begin
                                            state_next = S_ALU;
                                            step_next  = 4'd7;
                                        end
                                        default:
                                        begin
                                            // LDW: read word at popped address
                                            kind_next = K_RDW; hi_next = 1'b1;
                                            maddr_next = rd_reg;
                                        end
                                    endcase
                                end
                            end
                            4'd3: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = a_reg + 16'd1;
                                  step_next = 4'd7; end
                            4'd4: begin kind_next = K_WRW; maddr_next = rsp_reg;
                                  mwdata_next = wd_reg[7:0]; end
                            4'd5: begin kind_next = K_WRW; maddr_next = rsp_reg - 16'd1;
                                  mwdata_next = wd_reg[15:8]; end
                            4'd6:
                            begin
                                rsp_next = rsp_reg - 16'd2;
                                state_next = S_OUT;
                            end
                            4'd7:
                            begin
                                // push rd (LDW) or wd (NOT result) on data stack
                                if (op_reg == OP_LDW)
                                    wd_next = rd_reg;
                                kind_next = K_WRW; maddr_next = dsp_reg;
                                mwdata_next = (op_reg == OP_LDW) ? rd_reg[7:0] : wd_reg[7:0];
                            end
                            4'd8: begin kind_next = K_WRW; maddr_next = dsp_reg - 16'd1;
                                  mwdata_next = wd_reg[15:8]; end
                            default:
                            begin
                                dsp_next = dsp_reg - 16'd2;
                                pc_next  = pc_reg + 16'd1;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    OP_SWP, OP_ROT, OP_OVR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND,
                    OP_OR, OP_SHL, OP_SHR, OP_EQU, OP_SLT, OP_BRA, OP_STW:
                    begin
                        // pop a, b (and c for ROT), then push the results, branch (BRA) or
                        // store (STW); maddr tracks dsp as it moves; pushes staged in wd
                        unique case (step_reg)
                            4'd0: begin kind_next = K_RDW; hi_next = 1'b1;
                                  maddr_next = dsp_reg + 16'd1; end
                            4'd1: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = dsp_reg + 16'd2; end
                            4'd2: begin a_next = rd_reg; kind_next = K_RDW; hi_next = 1'b1;
                                  maddr_next = dsp_reg + 16'd3; end
                            4'd3: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = dsp_reg + 16'd4; end
                            4'd4:
                            begin
                                b_next = rd_reg;
                                if (op_reg == OP_ROT)
                                begin
                                    kind_next = K_RDW; hi_next = 1'b1;
                                    maddr_next = dsp_reg + 16'd5;
                                end
                                else if (op_reg == OP_SWP || op_reg == OP_OVR)
                                begin
                                    dsp_next = dsp_reg + 16'd4;
                                    state_next = S_DEC;
                                    step_next = 4'd7;
                                end
                                else if (op_reg == OP_BRA)
                                begin
                                    dsp_next = dsp_reg + 16'd4;
                                    pc_next = pc_reg + ((rd_reg != 16'd0) ? a_reg : 16'd1);
                                    state_next = S_OUT;
                                end
                                else if (op_reg == OP_STW)
                                begin
                                    dsp_next = dsp_reg + 16'd4;
                                    kind_next = K_WRW; maddr_next = a_reg;
                                    mwdata_next = rd_reg[15:8];
                                    step_next = 4'd13;
                                end
                                else
                                begin
                                    dsp_next = dsp_reg + 16'd4;
                                    state_next = S_ALU;
                                    step_next = 4'd11;
                                end
                            end
                            4'd5: begin kind_next = K_RDW; hi_next = 1'b0;
                                  maddr_next = dsp_reg + 16'd6; end
                            4'd6:
                            begin
                                c_next = rd_reg;
                                dsp_next = dsp_reg + 16'd6;
                                state_next = S_DEC;
                            end
                            4'd7:
                            begin
                                // first push: a for SWP/ROT, b for OVR
                                // later pushes come from b, then c
                                wd_next = (op_reg == OP_OVR) ? b_reg : a_reg;
                                if (op_reg == OP_SWP)
                                    push_left_next = 2'd1;
                                else
                                    push_left_next = 2'd2;
                                if (op_reg == OP_ROT)
                                begin
                                    b_next = c_reg; c_next = b_reg;
                                end
                                else if (op_reg == OP_OVR)
                                begin
                                    b_next = a_reg; c_next = b_reg;
                                end
                                state_next = S_DEC;
                                step_next = 4'd8;
                            end
                            4'd8: begin kind_next = K_WRW; maddr_next = dsp_reg;
                                  mwdata_next = wd_reg[7:0]; end
                            4'd9: begin kind_next = K_WRW; maddr_next = dsp_reg - 16'd1;
                                  mwdata_next = wd_reg[15:8]; end
                            4'd10:
                            begin
                                // push done; take the next staged value or finish
                                dsp_next = dsp_reg - 16'd2;
                                if (push_left_reg == 2'd0)
                                begin
                                    pc_next = pc_reg + 16'd1;
                                    state_next = S_OUT;
                                end
                                else
                                begin
                                    wd_next = b_reg;
                                    b_next = c_reg;
                                    push_left_next = push_left_reg - 2'd1;
                                    state_next = S_DEC;
                                    step_next = 4'd8;
                                end
                            end
                            4'd11: begin wd_next = alu_rsp.result; step_next = 4'd8;
                                   kind_next = K_CMDR; state_next = S_DEC; end
                            4'd13: begin kind_next = K_WRW; maddr_next = a_reg + 16'd1;
                                   mwdata_next = b_reg[7:0]; end
                            default:
                            begin
                                pc_next = pc_reg + 16'd1;
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    default:
                    begin
                        pc_next  = pc_reg + 16'd1;
                        bad_next = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ALU:
            begin
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (alu_rsp.done)
                begin
                    wd_next = alu_rsp.result;
                    state_next = S_DEC;
                    if (op_reg == OP_NOT)
                        step_next = 4'd7;
                    else
                    begin
                        step_next = 4'd8;
                        kind_next = K_CMDR;
                        push_left_next = 2'd0;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // NOT uses a as its operand; remap push value for NOT step 7
        if (state_reg == S_DEC && op_reg == OP_NOT && step_reg == 4'd7)
            mwdata_next = wd_reg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= 16'd0;
            dsp_reg   <= DSP_RST;
            rsp_reg   <= RSP_RST;
            step_reg  <= 4'd0;
            kind_reg  <= K_OPC;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            dsp_reg   <= dsp_next;
            rsp_reg   <= rsp_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        push_left_reg <= push_left_next;
        maddr_reg  <= maddr_next;
        mwdata_reg <= mwdata_next;
        op_reg     <= op_next;
        rd_reg     <= rd_next;
        wd_reg     <= wd_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        rb_reg     <= rb_next;
        bad_reg    <= bad_next;
    end

`ifndef SYNTHESIS
    // no new transaction while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while result pending");
    // a stalled result keeps its program counter and data stack pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(program_counter)
                                       && $stable(data_stack_pointer)))
        else $error("result changed under stall");
    // memory is only written during a transaction
    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> !in_ready)
        else $error("memory write while idle");
`endif
endmodule
`default_nettype wire
